>>> sv/scp_pkg.sv
// Shared types and constants of the slope collapse path walker.
// No dependencies; scp_if, the top level and the testbench import this package.
package scp_pkg;

  localparam int IN_COORD_W = 7;
  localparam int IN_VALUE_W = 32;
  localparam int OUT_STEP_W = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int FLAG_OVERSTEEP = 0;
  localparam int FLAG_FLOODED   = 1;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 2'd0,
    CFG_GRID_COLS = 2'd1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_WAIT,
    ST_RESULT,
    ST_W_CHECK,
    ST_W_CELL,
    ST_W_NBR,
    ST_W_SUM_E,
    ST_W_SOIL_T,
    ST_W_SOIL_S,
    ST_W_EDGE_RD,
    ST_W_EDGE_WR,
    ST_W_CAP_T,
    ST_W_CAP_S,
    ST_W_DECIDE,
    ST_W_CHG_RD,
    ST_W_CHG_SUB,
    ST_W_CHG_ADD,
    ST_W_ADVANCE
  } state_t;

endpackage

>>> sv/scp_if.sv
// Handshake interfaces of the slope collapse path walker: command input,
// result output and configuration write. Depends on scp_pkg.
interface scp_in_if import scp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [IN_COORD_W-1:0]   cell_row;
  logic [IN_COORD_W-1:0]   cell_col;
  logic [IN_COORD_W-1:0]   next_row;
  logic [IN_COORD_W-1:0]   next_col;
  logic signed [IN_VALUE_W-1:0] elevation;
  logic signed [IN_VALUE_W-1:0] critical_height;
  logic signed [IN_VALUE_W-1:0] sediment_thickness;
  logic [1:0]              cell_flags;
  logic signed [IN_VALUE_W-1:0] initial_drop;
  logic                    movement_is_soil;
  logic                    walk_enabled;

  modport source (output valid, command, cell_row, cell_col, next_row, next_col,
                  elevation, critical_height, sediment_thickness, cell_flags,
                  initial_drop, movement_is_soil, walk_enabled, input ready);
  modport sink (input valid, command, cell_row, cell_col, next_row, next_col,
                elevation, critical_height, sediment_thickness, cell_flags,
                initial_drop, movement_is_soil, walk_enabled, output ready);
endinterface

interface scp_out_if import scp_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [IN_VALUE_W-1:0] thickness_change;
  logic                         ended_at_boundary;
  logic                         ended_stable;
  logic [OUT_STEP_W-1:0]        step_count;
  logic                         step_limit_hit;

  modport source (output valid, thickness_change, ended_at_boundary, ended_stable,
                  step_count, step_limit_hit, input ready);
  modport sink (input valid, thickness_change, ended_at_boundary, ended_stable,
                step_count, step_limit_hit, output ready);
endinterface

interface scp_cfg_if import scp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/scp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/scp_alu.sv
// Shared saturating adder/subtractor used by every value sum and difference of a walk.
// No dependencies.
module scp_alu #(
  parameter int W = 32
) (
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic                sub,
  output logic signed [W-1:0] y
);
  logic signed [W:0] s;
  logic              ovf;

  always_comb begin
    if (sub) begin
      s = {a[W-1], a} - {b[W-1], b};
    end else begin
      s = {a[W-1], a} + {b[W-1], b};
    end
    ovf = s[W] ^ s[W-1];
    if (ovf) begin
      y = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      y = s[W-1:0];
    end
  end
endmodule

>>> sv/slope_collapse_path_walk_top.sv
// Channel     | Dir | Handshake        | Payload
// in_ch       | in  | valid/ready      | command, cell and neighbour, cell data, run setup
// out_ch      | out | valid/ready      | thickness_change, run end flags, step_count
// cfg_ch      | in  | valid/ready      | index (0 rows, 1 cols), data
// After reset a clearing pass zeroes every entry of the change store while no item is
// taken; configuration writes are taken at all times.
// Load, unused commands and a disabled run go from idle straight to the result state;
// a read passes through a read wait state first. A run steps from cell to cell through
// the walk states, paced by the shared saturating adder and the single read port of
// each store, until it ends at the edge, stable, or at the step limit.
// A finished result waits in the output register while the next item is taken.
// Top level of the slope collapse path walker. Depends on scp_pkg, scp_if,
// scp_ram and scp_alu.
module slope_collapse_path_walk_top
  import scp_pkg::*;
#(
  parameter int MAX_ROWS    = 128,
  parameter int MAX_COLS    = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  scp_in_if.sink         in_ch,
  scp_out_if.source      out_ch,
  scp_cfg_if.sink        cfg_ch
);
  localparam int VW     = VALUE_WIDTH;
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(CELLS);
  localparam int MAXD   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIM_W  = ($clog2(MAXD + 1) > CFG_DATA_W) ? $clog2(MAXD + 1) : CFG_DATA_W;
  localparam int LIM_W  = $clog2(CELLS + 1);
  localparam int SC_W   = (LIM_W > OUT_STEP_W) ? LIM_W : OUT_STEP_W;
  localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;

  typedef struct packed {
    logic [RW-1:0]        nrow;
    logic [CW-1:0]        ncol;
    logic signed [VW-1:0] elev;
    logic signed [VW-1:0] crit;
    logic signed [VW-1:0] sed;
    logic [1:0]           flags;
  } cell_t;

  function automatic logic signed [VW-1:0] sat_in(input logic signed [IN_VALUE_W-1:0] x);
    logic signed [63:0] wx;
    wx = 64'(x);
    if (wx > VMAX64) return VMAX64[VW-1:0];
    if (wx < VMIN64) return VMIN64[VW-1:0];
    return VW'(wx);
  endfunction

  function automatic logic [IN_VALUE_W-1:0] to_out(input logic signed [VW-1:0] v);
    logic signed [63:0] wv;
    wv = 64'(v);
    return wv[IN_VALUE_W-1:0];
  endfunction

  // Coordinates wrap modulo the store size; a lookup over the 7-bit range.
  function automatic logic [RW-1:0] row_wrap(input logic [IN_COORD_W-1:0] v);
    logic [RW-1:0] r;
    r = '0;
    for (int k = 0; k < (1 << IN_COORD_W); k++) begin
      if (v == IN_COORD_W'(k)) r = RW'(k % MAX_ROWS);
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] col_wrap(input logic [IN_COORD_W-1:0] v);
    logic [CW-1:0] r;
    r = '0;
    for (int k = 0; k < (1 << IN_COORD_W); k++) begin
      if (v == IN_COORD_W'(k)) r = CW'(k % MAX_COLS);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * MAX_COLS) + AW'(c);
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                 input int unsigned Max);
    logic [DIM_W-1:0] w;
    w = DIM_W'(v);
    if (w < DIM_W'(2)) return DIM_W'(2);
    if (w > DIM_W'(Max)) return DIM_W'(Max);
    return w;
  endfunction

  // Control registers.
  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CFG_DATA_W-1:0] grid_rows_r, grid_rows_nxt;
  logic [CFG_DATA_W-1:0] grid_cols_r, grid_cols_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;

  // Walk and result registers.
  logic [AW-1:0]         cur_r, cur_nxt;
  logic [AW-1:0]         nbr_r, nbr_nxt;
  logic signed [VW-1:0]  d1_r, d1_nxt;
  logic signed [VW-1:0]  d2_r, d2_nxt;
  logic signed [VW-1:0]  acc_r, acc_nxt;
  logic signed [VW-1:0]  sed_c_r, sed_c_nxt;
  logic                  flood_c_r, flood_c_nxt;
  logic signed [VW-1:0]  elev_n_r, elev_n_nxt;
  logic                  over_n_r, over_n_nxt;
  logic                  edge_r, edge_nxt;
  logic                  soil_r, soil_nxt;
  logic [DIM_W-1:0]      rows_r, rows_nxt;
  logic [DIM_W-1:0]      cols_r, cols_nxt;
  logic [LIM_W-1:0]      limit_r, limit_nxt;
  logic [SC_W-1:0]       steps_r, steps_nxt;
  logic                  at_bnd_r, at_bnd_nxt;
  logic                  stable_r, stable_nxt;
  logic                  hit_r, hit_nxt;
  logic signed [VW-1:0]  res_change_r, res_change_nxt;

  logic [IN_VALUE_W-1:0] o_change_r, o_change_nxt;
  logic                  o_bnd_r, o_bnd_nxt;
  logic                  o_stable_r, o_stable_nxt;
  logic [OUT_STEP_W-1:0] o_steps_r, o_steps_nxt;
  logic                  o_hit_r, o_hit_nxt;

  // Store ports.
  logic                  cell_we;
  logic [AW-1:0]         cell_waddr, cell_raddr;
  cell_t                 cell_wdata, cell_rdata;
  logic                  chg_we;
  logic [AW-1:0]         chg_waddr, chg_raddr;
  logic signed [VW-1:0]  chg_wdata, chg_rdata;

  // Shared arithmetic unit.
  logic signed [VW-1:0]  alu_a, alu_b, alu_y;
  logic                  alu_sub;

  logic                  in_fire, cfg_fire;
  logic [AW-1:0]         in_addr;
  logic [DIM_W-1:0]      rows_in, cols_in;
  logic [DIM_W-1:0]      ny_w, nx_w;
  logic                  edge_rd;

  scp_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  scp_ram #(.WIDTH(VW), .DEPTH(CELLS)) u_chg_ram (
    .clk   (clk),
    .we    (chg_we),
    .waddr (chg_waddr),
    .wdata (chg_wdata),
    .raddr (chg_raddr),
    .rdata (chg_rdata)
  );

  scp_alu #(.W(VW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.thickness_change  = o_change_r;
  assign out_ch.ended_at_boundary = o_bnd_r;
  assign out_ch.ended_stable      = o_stable_r;
  assign out_ch.step_count        = o_steps_r;
  assign out_ch.step_limit_hit    = o_hit_r;

  assign in_addr = cell_addr(row_wrap(in_ch.cell_row), col_wrap(in_ch.cell_col));
  assign rows_in = clamp_dim(grid_rows_r, MAX_ROWS);
  assign cols_in = clamp_dim(grid_cols_r, MAX_COLS);

  // A neighbour in the first row or column, or on or beyond the last row or column in use, counts as the edge.
  assign ny_w    = DIM_W'(cell_rdata.nrow);
  assign nx_w    = DIM_W'(cell_rdata.ncol);
  assign edge_rd = (ny_w == '0) || (ny_w >= rows_r - DIM_W'(1)) ||
                   (nx_w == '0) || (nx_w >= cols_r - DIM_W'(1));

  always_comb begin
    grid_rows_nxt = grid_rows_r;
    grid_cols_nxt = grid_cols_r;
    if (cfg_fire) begin
      case (cfg_ch.index)
        CFG_GRID_ROWS: grid_rows_nxt = cfg_ch.data;
        CFG_GRID_COLS: grid_cols_nxt = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    nbr_nxt        = nbr_r;
    d1_nxt         = d1_r;
    d2_nxt         = d2_r;
    acc_nxt        = acc_r;
    sed_c_nxt      = sed_c_r;
    flood_c_nxt    = flood_c_r;
    elev_n_nxt     = elev_n_r;
    over_n_nxt     = over_n_r;
    edge_nxt       = edge_r;
    soil_nxt       = soil_r;
    rows_nxt       = rows_r;
    cols_nxt       = cols_r;
    limit_nxt      = limit_r;
    steps_nxt      = steps_r;
    at_bnd_nxt     = at_bnd_r;
    stable_nxt     = stable_r;
    hit_nxt        = hit_r;
    res_change_nxt = res_change_r;

    cell_we    = 1'b0;
    cell_waddr = in_addr;
    cell_wdata = '{nrow:  row_wrap(in_ch.next_row),
                   ncol:  col_wrap(in_ch.next_col),
                   elev:  sat_in(in_ch.elevation),
                   crit:  sat_in(in_ch.critical_height),
                   sed:   sat_in(in_ch.sediment_thickness),
                   flags: in_ch.cell_flags};
    cell_raddr = cur_r;
    chg_we     = 1'b0;
    chg_waddr  = cur_r;
    chg_wdata  = '0;
    chg_raddr  = cur_r;
    alu_a      = d2_r;
    alu_b      = sed_c_r;
    alu_sub    = 1'b0;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_change_nxt  = o_change_r;
    o_bnd_nxt     = o_bnd_r;
    o_stable_nxt  = o_stable_r;
    o_steps_nxt   = o_steps_r;
    o_hit_nxt     = o_hit_r;

    unique case (state_r)
      ST_CLEAR: begin
        chg_we    = 1'b1;
        chg_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_change_nxt = '0;
          at_bnd_nxt     = 1'b0;
          stable_nxt     = 1'b0;
          hit_nxt        = 1'b0;
          steps_nxt      = '0;
          state_nxt      = ST_RESULT;
          case (cmd_t'(in_ch.command))
            CMD_LOAD: begin
              cell_we   = 1'b1;
              chg_we    = 1'b1;
              chg_waddr = in_addr;
            end
            CMD_RUN: begin
              if (in_ch.walk_enabled) begin
                cur_nxt   = in_addr;
                d1_nxt    = sat_in(in_ch.initial_drop);
                soil_nxt  = in_ch.movement_is_soil;
                rows_nxt  = rows_in;
                cols_nxt  = cols_in;
                limit_nxt = LIM_W'(rows_in) * LIM_W'(cols_in);
                state_nxt = ST_W_CHECK;
              end
            end
            CMD_READ: begin
              chg_raddr = in_addr;
              state_nxt = ST_READ_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_READ_WAIT: begin
        res_change_nxt = chg_rdata;
        state_nxt      = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_change_nxt  = to_out(res_change_r);
          o_bnd_nxt     = at_bnd_r;
          o_stable_nxt  = stable_r;
          o_steps_nxt   = steps_r[OUT_STEP_W-1:0];
          o_hit_nxt     = hit_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_W_CHECK: begin
        // The step limit guards against neighbour chains that loop.
        if (steps_r >= SC_W'(limit_r)) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          cell_raddr = cur_r;
          state_nxt  = ST_W_CELL;
        end
      end
      ST_W_CELL: begin
        alu_a       = cell_rdata.crit;
        alu_b       = cell_rdata.elev;
        alu_sub     = 1'b1;
        acc_nxt     = alu_y;
        sed_c_nxt   = cell_rdata.sed;
        flood_c_nxt = cell_rdata.flags[FLAG_FLOODED];
        edge_nxt    = edge_rd;
        nbr_nxt     = cell_addr(cell_rdata.nrow, cell_rdata.ncol);
        cell_raddr  = cell_addr(cell_rdata.nrow, cell_rdata.ncol);
        state_nxt   = ST_W_NBR;
      end
      ST_W_NBR: begin
        alu_a      = acc_r;
        alu_b      = d1_r;
        acc_nxt    = alu_y;
        elev_n_nxt = cell_rdata.elev;
        over_n_nxt = cell_rdata.flags[FLAG_OVERSTEEP];
        state_nxt  = ST_W_SUM_E;
      end
      ST_W_SUM_E: begin
        alu_a  = acc_r;
        alu_b  = elev_n_r;
        d2_nxt = (edge_r || over_n_r) ? alu_y : (alu_y >>> 1);
        if (edge_r) begin
          at_bnd_nxt = 1'b1;
          if (alu_y[VW-1]) begin
            state_nxt = soil_r ? ST_W_SOIL_T : ST_W_EDGE_RD;
          end else begin
            state_nxt = ST_W_CAP_T;
          end
        end else begin
          state_nxt = ST_W_CAP_T;
        end
      end
      ST_W_SOIL_T: begin
        state_nxt = alu_y[VW-1] ? ST_W_SOIL_S : ST_W_EDGE_RD;
      end
      ST_W_SOIL_S: begin
        alu_a     = d1_r;
        alu_sub   = 1'b1;
        d2_nxt    = alu_y;
        state_nxt = ST_W_EDGE_RD;
      end
      ST_W_EDGE_RD: begin
        chg_raddr = nbr_r;
        state_nxt = ST_W_EDGE_WR;
      end
      ST_W_EDGE_WR: begin
        alu_a     = chg_rdata;
        alu_b     = d2_r;
        alu_sub   = 1'b1;
        chg_we    = 1'b1;
        chg_waddr = nbr_r;
        chg_wdata = alu_y;
        state_nxt = ST_W_CAP_T;
      end
      ST_W_CAP_T: begin
        // The drop can never remove more than the sediment on the cell.
        state_nxt = alu_y[VW-1] ? ST_W_CAP_S : ST_W_DECIDE;
      end
      ST_W_CAP_S: begin
        alu_a     = d1_r;
        alu_sub   = 1'b1;
        d2_nxt    = alu_y;
        state_nxt = ST_W_DECIDE;
      end
      ST_W_DECIDE: begin
        chg_raddr = cur_r;
        if (!d2_r[VW-1] || flood_c_r) begin
          stable_nxt = 1'b1;
          state_nxt  = ST_W_CHG_RD;
        end else if (d2_r >= d1_r) begin
          state_nxt = ST_W_CHG_RD;
        end else begin
          state_nxt = ST_W_ADVANCE;
        end
      end
      ST_W_CHG_RD: begin
        alu_a     = chg_rdata;
        alu_b     = d1_r;
        alu_sub   = 1'b1;
        state_nxt = ST_W_CHG_SUB;
      end
      ST_W_CHG_SUB: begin
        alu_a   = chg_rdata;
        alu_b   = d1_r;
        alu_sub = 1'b1;
        if (stable_r) begin
          chg_we    = 1'b1;
          chg_wdata = alu_y;
          state_nxt = ST_W_ADVANCE;
        end else begin
          acc_nxt   = alu_y;
          state_nxt = ST_W_CHG_ADD;
        end
      end
      ST_W_CHG_ADD: begin
        alu_a     = acc_r;
        alu_b     = d2_r;
        chg_we    = 1'b1;
        chg_wdata = alu_y;
        d1_nxt    = d2_r;
        state_nxt = ST_W_ADVANCE;
      end
      ST_W_ADVANCE: begin
        steps_nxt = steps_r + SC_W'(1);
        cur_nxt   = nbr_r;
        state_nxt = (at_bnd_r || stable_r) ? ST_RESULT : ST_W_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      grid_rows_r <= CFG_DATA_W'(128);
      grid_cols_r <= CFG_DATA_W'(128);
      clr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
      clr_r       <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    nbr_r        <= nbr_nxt;
    d1_r         <= d1_nxt;
    d2_r         <= d2_nxt;
    acc_r        <= acc_nxt;
    sed_c_r      <= sed_c_nxt;
    flood_c_r    <= flood_c_nxt;
    elev_n_r     <= elev_n_nxt;
    over_n_r     <= over_n_nxt;
    edge_r       <= edge_nxt;
    soil_r       <= soil_nxt;
    rows_r       <= rows_nxt;
    cols_r       <= cols_nxt;
    limit_r      <= limit_nxt;
    steps_r      <= steps_nxt;
    at_bnd_r     <= at_bnd_nxt;
    stable_r     <= stable_nxt;
    hit_r        <= hit_nxt;
    res_change_r <= res_change_nxt;
    o_change_r   <= o_change_nxt;
    o_bnd_r      <= o_bnd_nxt;
    o_stable_r   <= o_stable_nxt;
    o_steps_r    <= o_steps_nxt;
    o_hit_r      <= o_hit_nxt;
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("accepted item did not start work");

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_W_CHECK) |-> (steps_r <= SC_W'(limit_r)))
    else $error("walk ran past the step limit");

  a_single_end_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT) |-> !(hit_r && (at_bnd_r || stable_r)))
    else $error("step limit reported together with another end cause");

  a_clear_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == ST_CLEAR && state_r == ST_IDLE) |-> (clr_r == '0))
    else $error("clearing pass left early");
`endif
endmodule

>>> bench/tb_slope_collapse_path_walk_top.sv
// Self-checking testbench of the slope collapse path walker top level.
// Drives items through scp_in_if and configuration through scp_cfg_if, and checks
// every result against an internal terrain predictor. Depends on scp_pkg, scp_if and the RTL.
module tb_slope_collapse_path_walk_top;
  import scp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_SIDE = 128;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  typedef struct {
    logic [1:0]         command;
    logic [6:0]         cell_row, cell_col, next_row, next_col;
    logic signed [31:0] elevation, critical_height, sediment_thickness;
    logic [1:0]         cell_flags;
    logic signed [31:0] initial_drop;
    logic               movement_is_soil, walk_enabled;
  } terrain_cmd_t;

  typedef struct {
    logic signed [31:0] thickness_change;
    logic               at_boundary, stable;
    logic [14:0]        steps;
    logic               limit_hit;
  } walk_result_t;

  logic clk;
  logic rst_n;

  scp_in_if  in_if();
  scp_out_if out_if();
  scp_cfg_if cfg_if();

  slope_collapse_path_walk_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Terrain mirror of the block's stores.
  logic [6:0]  nrow_mem [CELL_COUNT];
  logic [6:0]  ncol_mem [CELL_COUNT];
  longint      elev_mem [CELL_COUNT];
  longint      crit_mem [CELL_COUNT];
  longint      sed_mem  [CELL_COUNT];
  logic [1:0]  flag_mem [CELL_COUNT];
  longint      chg_mem  [CELL_COUNT];
  bit          loaded   [CELL_COUNT];
  logic [7:0]  rows_reg, cols_reg;

  walk_result_t expected_q[$];
  int fail_count;
  int items_sent, n_loads, n_runs, n_reads;
  int n_boundary, n_stable, n_limit;
  int burst_left;
  bit no_gaps;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint sat32(longint x);
    if (x > QMAX) return QMAX;
    if (x < QMIN) return QMIN;
    return x;
  endfunction

  function automatic int rows_in_use();
    if (rows_reg < 2) return 2;
    if (rows_reg > GRID_SIDE) return GRID_SIDE;
    return rows_reg;
  endfunction

  function automatic int cols_in_use();
    if (cols_reg < 2) return 2;
    if (cols_reg > GRID_SIDE) return GRID_SIDE;
    return cols_reg;
  endfunction

  function automatic bit at_edge(int r, int c);
    return r == 0 || r >= rows_in_use() - 1 || c == 0 || c >= cols_in_use() - 1;
  endfunction

  // Walks the chain a run would follow and confirms that every cell it could
  // touch has been loaded; cycles are refused on grids of more than 1024 cells.
  function automatic bit chain_is_loaded(int r, int c);
    int cur;
    int nxt;
    bit seen [int];
    cur = r * GRID_SIDE + c;
    seen[cur] = 1;
    for (int i = 0; i <= CELL_COUNT; i++) begin
      if (!loaded[cur]) return 0;
      nxt = nrow_mem[cur] * GRID_SIDE + ncol_mem[cur];
      if (!loaded[nxt]) return 0;
      if (at_edge(nrow_mem[cur], ncol_mem[cur])) return 1;
      if (seen.exists(nxt)) return rows_in_use() * cols_in_use() <= 1024;
      seen[nxt] = 1;
      cur = nxt;
    end
    return 0;
  endfunction

  function automatic walk_result_t collapse_terrain(terrain_cmd_t it);
    walk_result_t res;
    int cur, nxt, limit;
    longint d1, d2, v;
    bit edge_hit;
    res = '{default: '0};
    cur = it.cell_row * GRID_SIDE + it.cell_col;
    case (it.command)
      CMD_LOAD: begin
        nrow_mem[cur] = it.next_row;
        ncol_mem[cur] = it.next_col;
        elev_mem[cur] = it.elevation;
        crit_mem[cur] = it.critical_height;
        sed_mem[cur]  = it.sediment_thickness;
        flag_mem[cur] = it.cell_flags;
        chg_mem[cur]  = 0;
        loaded[cur]   = 1;
      end
      CMD_READ: res.thickness_change = chg_mem[cur][31:0];
      CMD_RUN: if (it.walk_enabled) begin
        limit = rows_in_use() * cols_in_use();
        d1 = it.initial_drop;
        while (!res.at_boundary && !res.stable) begin
          if (res.steps >= limit) begin
            res.limit_hit = 1;
            break;
          end
          nxt = nrow_mem[cur] * GRID_SIDE + ncol_mem[cur];
          v = sat32(sat32(sat32(crit_mem[cur] - elev_mem[cur]) + d1) + elev_mem[nxt]);
          edge_hit = at_edge(nrow_mem[cur], ncol_mem[cur]);
          if (edge_hit) begin
            d2 = v;
            if (d2 < 0) begin
              if (it.movement_is_soil && sat32(d2 + sed_mem[cur]) < 0)
                d2 = sat32(d1 - sed_mem[cur]);
              chg_mem[nxt] = sat32(chg_mem[nxt] - d2);
            end
            res.at_boundary = 1;
          end else if (flag_mem[nxt][FLAG_OVERSTEEP]) begin
            d2 = v;
          end else begin
            d2 = v >>> 1;
          end
          if (sat32(d2 + sed_mem[cur]) < 0) d2 = sat32(d1 - sed_mem[cur]);
          if (d2 >= 0 || flag_mem[cur][FLAG_FLOODED]) begin
            chg_mem[cur] = sat32(chg_mem[cur] - d1);
            res.stable = 1;
          end else if (d2 >= d1) begin
            chg_mem[cur] = sat32(sat32(chg_mem[cur] - d1) + d2);
            d1 = d2;
          end
          res.steps++;
          cur = nxt;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Sends one item; valid is only lowered inside a gap, which always advances time.
  task automatic send_cmd(terrain_cmd_t it);
    int gap;
    walk_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : (($urandom % 4 == 0) ? 0 : $urandom_range(1, 8));
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid              <= 1'b1;
    in_if.command            <= it.command;
    in_if.cell_row           <= it.cell_row;
    in_if.cell_col           <= it.cell_col;
    in_if.next_row           <= it.next_row;
    in_if.next_col           <= it.next_col;
    in_if.elevation          <= it.elevation;
    in_if.critical_height    <= it.critical_height;
    in_if.sediment_thickness <= it.sediment_thickness;
    in_if.cell_flags         <= it.cell_flags;
    in_if.initial_drop       <= it.initial_drop;
    in_if.movement_is_soil   <= it.movement_is_soil;
    in_if.walk_enabled       <= it.walk_enabled;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    res = collapse_terrain(it);
    expected_q.push_back(res);
    items_sent++;
    case (it.command)
      CMD_LOAD: n_loads++;
      CMD_RUN: n_runs++;
      CMD_READ: n_reads++;
      default: ;
    endcase
    if (res.at_boundary) n_boundary++;
    if (res.stable) n_stable++;
    if (res.limit_hit) n_limit++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == CFG_GRID_ROWS) rows_reg = value;
    else cols_reg = value;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(logic [7:0] r, logic [7:0] c);
    drain();
    write_reg(CFG_GRID_ROWS, r);
    write_reg(CFG_GRID_COLS, c);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom % 8)
      0: case ($urandom % 4)
        0: return 32'h7fffffff;
        1: return 32'h80000000;
        2: return 32'h0;
        default: return 32'hffffffff;
      endcase
      1: return $urandom;
      default: return $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
    endcase
  endfunction

  function automatic terrain_cmd_t rand_cmd();
    terrain_cmd_t it;
    it.command            = $urandom;
    it.cell_row           = $urandom;
    it.cell_col           = $urandom;
    it.next_row           = $urandom;
    it.next_col           = $urandom;
    it.elevation          = $urandom;
    it.critical_height    = $urandom;
    it.sediment_thickness = $urandom;
    it.cell_flags         = $urandom;
    it.initial_drop       = $urandom;
    it.movement_is_soil   = $urandom;
    it.walk_enabled       = $urandom;
    return it;
  endfunction

  function automatic terrain_cmd_t load_cmd(int r, int c, int nr, int nc, logic signed [31:0] el,
                                            logic signed [31:0] cr, logic signed [31:0] sd,
                                            logic [1:0] fl);
    terrain_cmd_t it;
    it = rand_cmd();
    it.command = CMD_LOAD;
    it.cell_row = r;
    it.cell_col = c;
    it.next_row = nr;
    it.next_col = nc;
    it.elevation = el;
    it.critical_height = cr;
    it.sediment_thickness = sd;
    it.cell_flags = fl;
    return it;
  endfunction

  function automatic terrain_cmd_t run_cmd(int r, int c, logic signed [31:0] drop, bit soil,
                                           bit en);
    terrain_cmd_t it;
    it = rand_cmd();
    it.command = CMD_RUN;
    it.cell_row = r;
    it.cell_col = c;
    it.initial_drop = drop;
    it.movement_is_soil = soil;
    it.walk_enabled = en;
    return it;
  endfunction

  function automatic terrain_cmd_t read_cmd(int r, int c);
    terrain_cmd_t it;
    it = rand_cmd();
    it.command = CMD_READ;
    it.cell_row = r;
    it.cell_col = c;
    return it;
  endfunction

  // Receiver: stalls on a pattern that is picked anew at random, honors long
  // hold-offs, and checks each accepted result against the oldest expectation.
  initial begin
    int mode;
    int phase;
    walk_result_t exp_res;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result arrived with no expectation waiting");
          fail_count++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_if.thickness_change !== exp_res.thickness_change) begin
            $error("thickness_change expected %0d actual %0d",
                   exp_res.thickness_change, out_if.thickness_change);
            fail_count++;
          end
          if (out_if.ended_at_boundary !== exp_res.at_boundary) begin
            $error("ended_at_boundary expected %0b actual %0b",
                   exp_res.at_boundary, out_if.ended_at_boundary);
            fail_count++;
          end
          if (out_if.ended_stable !== exp_res.stable) begin
            $error("ended_stable expected %0b actual %0b", exp_res.stable, out_if.ended_stable);
            fail_count++;
          end
          if (out_if.step_count !== exp_res.steps) begin
            $error("step_count expected %0d actual %0d", exp_res.steps, out_if.step_count);
            fail_count++;
          end
          if (out_if.step_limit_hit !== exp_res.limit_hit) begin
            $error("step_limit_hit expected %0b actual %0b",
                   exp_res.limit_hit, out_if.step_limit_hit);
            fail_count++;
          end
        end
      end
      phase++;
      if (phase % 64 == 0) mode = $urandom % 3;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= $urandom % 2;
          default: out_if.ready <= (phase % 4 == 0);
        endcase
      end
    end
  end

  task automatic test_load_and_read();
    terrain_cmd_t it;
    send_cmd(read_cmd(0, 0));
    send_cmd(load_cmd(127, 127, 127, 127, 32'h7fffffff, 32'h80000000, 32'h80000000, 2'b11));
    send_cmd(read_cmd(127, 127));
    send_cmd(load_cmd(0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 2'b00));
    it = rand_cmd();
    it.command = CMD_UNUSED;
    send_cmd(it);
    send_cmd(run_cmd(127, 127, 32'h80000000, 1'b1, 1'b1));
    send_cmd(read_cmd(127, 127));
    send_cmd(run_cmd(0, 0, 32'h7fffffff, 1'b0, 1'b1));
    send_cmd(read_cmd(0, 0));
  endtask

  task automatic test_walk_cases();
    set_grid(8'd8, 8'd8);
    send_cmd(load_cmd(2, 2, 3, 3, 0, 0, 32'h00100000, 2'b00));
    send_cmd(load_cmd(3, 3, 0, 5, 0, 0, 32'h00002000, 2'b00));
    send_cmd(load_cmd(0, 5, 0, 5, -32'sh10000, 0, 0, 2'b00));
    send_cmd(run_cmd(2, 2, -32'sh8000, 1'b1, 1'b1));
    send_cmd(run_cmd(2, 2, -32'sh8000, 1'b0, 1'b1));
    send_cmd(run_cmd(2, 2, -32'sh8000, 1'b1, 1'b0));
    send_cmd(read_cmd(2, 2));
    send_cmd(read_cmd(0, 5));
    // Oversteep neighbour skips the halving; flooded start ends at once.
    send_cmd(load_cmd(3, 3, 0, 5, 0, 0, 32'h7fffffff, 2'b01));
    send_cmd(load_cmd(4, 4, 3, 3, 32'h00010000, 0, 32'h00100000, 2'b00));
    send_cmd(run_cmd(4, 4, -32'sh40000, 1'b0, 1'b1));
    send_cmd(load_cmd(5, 5, 2, 2, 0, 0, 32'h00100000, 2'b10));
    send_cmd(run_cmd(5, 5, -32'sh40000, 1'b1, 1'b1));
    send_cmd(read_cmd(5, 5));
    send_cmd(read_cmd(3, 3));
  endtask

  task automatic test_step_limit();
    set_grid(8'd4, 8'd4);
    send_cmd(load_cmd(1, 1, 1, 2, 0, 0, 32'h7fffffff, 2'b00));
    send_cmd(load_cmd(1, 2, 1, 1, 0, 0, 32'h7fffffff, 2'b00));
    send_cmd(run_cmd(1, 1, -32'sh3e8, 1'b0, 1'b1));
    send_cmd(read_cmd(1, 1));
    send_cmd(read_cmd(1, 2));
  endtask

  task automatic test_backpressure();
    drain();
    no_gaps = 1;
    hold_cycles = 400;
    for (int i = 0; i < 30; i++)
      send_cmd((i % 2) ? read_cmd($urandom, $urandom) :
               load_cmd($urandom, $urandom, $urandom, $urandom, rand_q(), rand_q(), rand_q(),
                        $urandom));
    no_gaps = 0;
  endtask

  // Loads a chain of cells, interior where the grid has room, that ends at the edge, or in a
  // cycle on small grids, then runs from its head and reads it back.
  task automatic run_random_path();
    int ru, cu, len;
    int pr[16], pc[16];
    int er, ec;
    bit loop_back;
    ru = rows_in_use();
    cu = cols_in_use();
    len = (ru < 3 || cu < 3) ? 1 : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      pr[i] = (ru < 3) ? 0 : $urandom_range(1, ru - 2);
      pc[i] = (cu < 3) ? 0 : $urandom_range(1, cu - 2);
    end
    case ($urandom % 4)
      0: begin er = 0; ec = $urandom_range(0, 127); end
      1: begin er = $urandom_range(ru - 1, 127); ec = $urandom_range(0, 127); end
      2: begin er = $urandom_range(0, 127); ec = 0; end
      default: begin er = $urandom_range(0, 127); ec = $urandom_range(cu - 1, 127); end
    endcase
    loop_back = ru >= 3 && cu >= 3 && ru * cu <= 1024 && $urandom % 8 == 0;
    for (int i = 0; i < len; i++) begin
      if (i < len - 1)
        send_cmd(load_cmd(pr[i], pc[i], pr[i + 1], pc[i + 1], rand_q(), rand_q(),
                          $urandom_range(0, 32'h400000), ($urandom % 4 == 0) ? $urandom : 0));
      else if (loop_back)
        send_cmd(load_cmd(pr[i], pc[i], pr[0], pc[0], rand_q(), rand_q(), rand_q(), $urandom));
      else
        send_cmd(load_cmd(pr[i], pc[i], er, ec, rand_q(), rand_q(), rand_q(),
                          ($urandom % 4 == 0) ? $urandom : 0));
    end
    send_cmd(load_cmd(er, ec, $urandom, $urandom, rand_q(), rand_q(), rand_q(), $urandom));
    for (int k = 0; k < 2; k++) begin
      if (chain_is_loaded(pr[0], pc[0]))
        send_cmd(run_cmd(pr[0], pc[0],
                         ($urandom % 4 == 0) ? rand_q() : -$signed($urandom_range(1, 32'h100000)),
                         $urandom, 1'b1));
    end
    send_cmd(read_cmd(pr[0], pc[0]));
    send_cmd(read_cmd(pr[len - 1], pc[len - 1]));
    send_cmd(read_cmd(er, ec));
  endtask

  task automatic send_noise();
    terrain_cmd_t it;
    it = rand_cmd();
    if (it.command == CMD_LOAD) begin
      it.elevation = rand_q();
      it.critical_height = rand_q();
      it.sediment_thickness = rand_q();
    end else if (it.command == CMD_RUN && it.walk_enabled &&
                 !chain_is_loaded(it.cell_row, it.cell_col)) begin
      it.walk_enabled = 1'b0;
    end
    send_cmd(it);
  endtask

  task automatic test_random(int target);
    logic [7:0] grid_pick [8] = '{8'd2, 8'd3, 8'd128, 8'd255, 8'd0, 8'd1, 8'd16, 8'd6};
    logic [7:0] r, c;
    while (items_sent < target) begin
      r = ($urandom % 3 == 0) ? 8'($urandom) : grid_pick[$urandom % 8];
      c = ($urandom % 3 == 0) ? 8'($urandom) : grid_pick[$urandom % 8];
      set_grid(r, c);
      for (int k = 0; k < 12 && items_sent < target; k++) begin
        if ($urandom % 5 == 0) send_noise();
        else run_random_path();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid <= 1'b0;
    in_if.command <= CMD_LOAD;
    in_if.cell_row <= '0;
    in_if.cell_col <= '0;
    in_if.next_row <= '0;
    in_if.next_col <= '0;
    in_if.elevation <= '0;
    in_if.critical_height <= '0;
    in_if.sediment_thickness <= '0;
    in_if.cell_flags <= '0;
    in_if.initial_drop <= '0;
    in_if.movement_is_soil <= 1'b0;
    in_if.walk_enabled <= 1'b0;
    out_if.ready <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_GRID_ROWS;
    cfg_if.data <= '0;
    rows_reg = 8'd128;
    cols_reg = 8'd128;
    for (int i = 0; i < CELL_COUNT; i++) begin
      chg_mem[i] = 0;
      loaded[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_and_read();
    test_walk_cases();
    test_step_limit();
    test_backpressure();
    test_random(1900);
    set_grid(8'd128, 8'd128);
    drain();

    $display("Covered %0d items: %0d loads, %0d runs, %0d reads.",
             items_sent, n_loads, n_runs, n_reads);
    $display("Runs ended at the edge %0d times, stable %0d times, at the step limit %0d times.",
             n_boundary, n_stable, n_limit);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> slope_collapse_path_walk_top.f
sv/scp_pkg.sv
sv/scp_if.sv
sv/scp_ram.sv
sv/scp_alu.sv
sv/slope_collapse_path_walk_top.sv
bench/tb_slope_collapse_path_walk_top.sv
